// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL; both sample on i_clk and drop checks in reset.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define UVSB_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define UVSB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/uvsb_pkg.sv
package uvsb_pkg;

    localparam int ANGLE_BINS_MAX_DEF = 8;
    localparam int RADIAL_BINS_DEF    = 256;
    localparam int CORDIC_STEPS       = 16;

    // configuration register indexes
    localparam logic [2:0] CFG_SIN_DEC    = 3'd0;
    localparam logic [2:0] CFG_COS_DEC    = 3'd1;
    localparam logic [2:0] CFG_DISH_DIAM  = 3'd2;
    localparam logic [2:0] CFG_DIAM_RECIP = 3'd3;
    localparam logic [2:0] CFG_BIN_ORIGIN = 3'd4;
    localparam logic [2:0] CFG_BW_RECIP   = 3'd5;
    localparam logic [2:0] CFG_ANGLE_BINS = 3'd6;

    // register reset values
    localparam logic signed [15:0] SIN_DEC_RST    = 16'sd0;
    localparam logic signed [15:0] COS_DEC_RST    = 16'sd16384;
    localparam logic [30:0]        DISH_DIAM_RST  = 31'd655360;
    localparam logic [31:0]        DIAM_RECIP_RST = 32'd1677722;
    localparam logic signed [31:0] BIN_ORIGIN_RST = 32'sd0;
    localparam logic [31:0]        BW_RECIP_RST   = 32'd16777216;
    localparam logic [3:0]         ANGLE_BINS_RST = 4'd8;

    localparam logic signed [32:0] HALF_TURN   = 33'sh040000000;
    localparam logic signed [32:0] QUART_TURN  = 33'sh020000000;
    localparam logic [16:0]        FULL_SHADOW = 17'd65536;
    localparam logic [23:0]        CNT_MAX     = 24'hFFFFFF;
    localparam logic [39:0]        SUM_MAX     = 40'hFF_FFFF_FFFF;
    localparam logic [30:0]        RADIUS_MAX  = 31'h7FFFFFFF;

    typedef struct packed {
        logic               restart;
        logic signed [31:0] delta_x;
        logic signed [31:0] delta_y;
        logic signed [31:0] delta_z;
        logic signed [15:0] sin_hour;
        logic signed [15:0] cos_hour;
    } t_sample;

    typedef struct packed {
        logic signed [31:0] u_coord;
        logic signed [31:0] v_coord;
        logic [30:0]        uv_radius;
        logic [16:0]        shadow_frac;
        logic [7:0]         radius_bin;
        logic [2:0]         angle_bin;
        logic [23:0]        bin_count;
        logic [39:0]        shadow_total;
        logic [16:0]        shadow_peak;
    } t_result;

    // arctangent of 2^-i in binary angle units, pi = 2^30
    function automatic logic [28:0] arc_angle(input logic [3:0] i);
        logic [28:0] a;
        case (i)
            4'd0:    a = 29'd268435456;
            4'd1:    a = 29'd158466703;
            4'd2:    a = 29'd83729454;
            4'd3:    a = 29'd42502379;
            4'd4:    a = 29'd21333666;
            4'd5:    a = 29'd10677233;
            4'd6:    a = 29'd5339919;
            4'd7:    a = 29'd2670122;
            4'd8:    a = 29'd1335082;
            4'd9:    a = 29'd667543;
            4'd10:   a = 29'd333772;
            4'd11:   a = 29'd166886;
            4'd12:   a = 29'd83443;
            4'd13:   a = 29'd41721;
            4'd14:   a = 29'd20861;
            4'd15:   a = 29'd10430;
            default: a = 29'd0;
        endcase
        return a;
    endfunction

endpackage

// File: hw/rtl/uvsb_chan_if.sv
interface uvsb_chan_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/uv_sample_binning_unit.sv
// uv_sample_binning_unit: projects one baseline sample onto the uv plane and bins it.
//
// Channels: i_sample (valid/ready sink, one request per baseline sample) and
// o_result (valid/ready source, one result per sample). Configuration goes in
// through i_cfg_we / i_cfg_index / i_cfg_wdata, one register per cycle; write
// only while no sample is in flight.
//
// Processing: one sample at a time. The work is done by the shared 33x33
// multiplier (12 products), the bit-serial square root, the 16-step CORDIC and
// a read-modify-write of the histogram memory. A sample with restart set first
// sweeps all ANGLE_BINS_MAX*RADIAL_BINS histogram entries to zero.
//
// Reset: configuration and control registers take their defaults and the
// histogram is swept to zero, one entry per cycle; i_sample.ready stays low
// until the sweep is done. Configuration writes are taken during the sweep.
//
// Stall: a finished result waits in the output register; the next sample is
// accepted meanwhile and runs until its own result needs that register.
`include "assert_macros.svh"

module uv_sample_binning_unit #(
    parameter int ANGLE_BINS_MAX = uvsb_pkg::ANGLE_BINS_MAX_DEF,
    parameter int RADIAL_BINS    = uvsb_pkg::RADIAL_BINS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    uvsb_chan_if.sink   i_sample,
    uvsb_chan_if.source o_result,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_wdata
);
    localparam int DEPTH = ANGLE_BINS_MAX * RADIAL_BINS;
    localparam int IW    = $clog2(DEPTH);
    localparam int RBW   = $clog2(RADIAL_BINS);
    localparam int ABW   = (ANGLE_BINS_MAX > 1) ? $clog2(ANGLE_BINS_MAX) : 1;
    localparam int NSW   = $clog2(ANGLE_BINS_MAX + 1);

    // sequencer states
    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_MUL    = 3'd2;
    localparam logic [2:0] ST_SQRT   = 3'd3;
    localparam logic [2:0] ST_CORDIC = 3'd4;
    localparam logic [2:0] ST_READ   = 3'd5;
    localparam logic [2:0] ST_WRITE  = 3'd6;

    // multiplier schedule
    localparam logic [3:0] MS_SH_DX  = 4'd0;
    localparam logic [3:0] MS_CH_DY  = 4'd1;
    localparam logic [3:0] MS_SD_CH  = 4'd2;
    localparam logic [3:0] MS_SD_SH  = 4'd3;
    localparam logic [3:0] MS_C1_DX  = 4'd4;
    localparam logic [3:0] MS_C2_DY  = 4'd5;
    localparam logic [3:0] MS_CD_DZ  = 4'd6;
    localparam logic [3:0] MS_UU     = 4'd7;
    localparam logic [3:0] MS_VV     = 4'd8;
    localparam logic [3:0] MS_SHADOW = 4'd9;
    localparam logic [3:0] MS_RHI    = 4'd10;
    localparam logic [3:0] MS_RLO    = 4'd11;

    // round at bit 14, floor semantics
    function automatic logic signed [37:0] rnd14(input logic signed [51:0] x);
        logic signed [51:0] t;
        t = x + 52'sd8192;
        return t[51:14];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [37:0] x);
        logic signed [31:0] s;
        if (!x[37] && (|x[36:31])) begin
            s = 32'sh7FFFFFFF;
        end else if (x[37] && !(&x[36:31])) begin
            s = 32'sh80000000;
        end else begin
            s = x[31:0];
        end
        return s;
    endfunction

    // configuration
    logic signed [15:0] r_sin_dec;
    logic signed [15:0] r_cos_dec;
    logic [30:0]        r_dish_diam;
    logic [31:0]        r_diam_recip;
    logic signed [31:0] r_bin_origin;
    logic [31:0]        r_bw_recip;
    logic [3:0]         r_angle_bins;

    // control
    logic [2:0]    r_state;
    logic [2:0]    n_state;
    logic [3:0]    r_step;
    logic          r_phase;
    logic          r_pending;
    logic [IW-1:0] r_clr_ptr;
    logic          r_sqrt_start;
    logic          r_cordic_start;

    // datapath
    uvsb_pkg::t_sample  r_in;
    logic signed [65:0] r_prod;
    logic signed [51:0] r_acc;
    logic signed [17:0] r_c1;
    logic signed [17:0] r_c2;
    logic signed [31:0] r_u;
    logic signed [31:0] r_v;
    logic [63:0]        r_sq;
    logic [30:0]        r_radius;
    logic [16:0]        r_frac;
    logic [48:0]        r_hi;
    logic [RBW-1:0]     r_rbin;
    logic [ABW-1:0]     r_abin;
    logic [IW-1:0]      r_idx;
    logic [39:0]        r_sum;
    logic [16:0]        r_peak;
    uvsb_pkg::t_result  r_out;
    logic               r_out_valid;

    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] prod_w;
    logic signed [51:0] prod52;
    logic signed [51:0] acc_sum;
    logic signed [37:0] rnd_prod;
    logic signed [37:0] rnd_acc;
    logic [30:0]        diam_diff;
    logic signed [33:0] bin_diff;
    logic               diff_pos;
    logic [38:0]        frac_raw;
    logic [16:0]        frac_w;
    logic [49:0]        rsum;
    logic [25:0]        rbin_raw;
    logic [RBW-1:0]     rbin_w;
    logic signed [32:0] fold_u;
    logic signed [32:0] fold_v;
    logic               out_free;
    logic               in_fire;
    logic               last_clear;

    logic               sqrt_done;
    logic [31:0]        sqrt_root;
    logic               cordic_done;
    logic [30:0]        cordic_angle;

    logic [NSW-1:0]     nsec;
    logic [30+NSW:0]    ang_prod;
    logic [NSW:0]       abin_raw;
    logic [ABW-1:0]     abin_w;
    logic [IW-1:0]      idx_w;

    logic               mem_we;
    logic [IW-1:0]      mem_waddr;
    logic [23:0]        mem_wdata;
    logic [23:0]        mem_rdata;
    logic [23:0]        cnt_w;
    logic [40:0]        sum_ext;
    logic [39:0]        sum_w;
    logic [16:0]        peak_w;

    // shared multiplier operands
    always_comb begin
        case (r_step)
            MS_SH_DX: begin
                mul_a = {{17{r_in.sin_hour[15]}}, r_in.sin_hour};
                mul_b = {r_in.delta_x[31], r_in.delta_x};
            end
            MS_CH_DY: begin
                mul_a = {{17{r_in.cos_hour[15]}}, r_in.cos_hour};
                mul_b = {r_in.delta_y[31], r_in.delta_y};
            end
            MS_SD_CH: begin
                mul_a = {{17{r_sin_dec[15]}}, r_sin_dec};
                mul_b = {{17{r_in.cos_hour[15]}}, r_in.cos_hour};
            end
            MS_SD_SH: begin
                mul_a = {{17{r_sin_dec[15]}}, r_sin_dec};
                mul_b = {{17{r_in.sin_hour[15]}}, r_in.sin_hour};
            end
            MS_C1_DX: begin
                mul_a = {{15{r_c1[17]}}, r_c1};
                mul_b = {r_in.delta_x[31], r_in.delta_x};
            end
            MS_C2_DY: begin
                mul_a = {{15{r_c2[17]}}, r_c2};
                mul_b = {r_in.delta_y[31], r_in.delta_y};
            end
            MS_CD_DZ: begin
                mul_a = {{17{r_cos_dec[15]}}, r_cos_dec};
                mul_b = {r_in.delta_z[31], r_in.delta_z};
            end
            MS_UU: begin
                mul_a = {r_u[31], r_u};
                mul_b = {r_u[31], r_u};
            end
            MS_VV: begin
                mul_a = {r_v[31], r_v};
                mul_b = {r_v[31], r_v};
            end
            MS_SHADOW: begin
                mul_a = {2'b00, diam_diff};
                mul_b = {1'b0, r_diam_recip};
            end
            MS_RHI: begin
                mul_a = {17'd0, bin_diff[31:16]};
                mul_b = {1'b0, r_bw_recip};
            end
            MS_RLO: begin
                mul_a = {17'd0, bin_diff[15:0]};
                mul_b = {1'b0, r_bw_recip};
            end
            default: begin
                mul_a = 33'sd0;
                mul_b = 33'sd0;
            end
        endcase
        prod_w = mul_a * mul_b;
    end

    // datapath around the registered product
    always_comb begin
        prod52    = $signed(r_prod[51:0]);
        acc_sum   = r_acc + prod52;
        rnd_prod  = rnd14(prod52);
        rnd_acc   = rnd14(acc_sum);
        diam_diff = r_dish_diam - r_radius;
        bin_diff  = $signed({3'b000, r_radius}) - $signed({{2{r_bin_origin[31]}}, r_bin_origin});
        diff_pos  = !bin_diff[33] && (bin_diff != 34'sd0);
        frac_raw  = r_prod[62:24];
        if (r_radius < r_dish_diam) begin
            frac_w = (frac_raw > {22'd0, uvsb_pkg::FULL_SHADOW}) ? uvsb_pkg::FULL_SHADOW
                                                                 : frac_raw[16:0];
        end else begin
            frac_w = 17'd0;
        end
        rsum     = {1'b0, r_hi} + {18'd0, r_prod[47:16]};
        rbin_raw = rsum[49:24];
        if (!diff_pos) begin
            rbin_w = '0;
        end else if (rbin_raw > 26'(RADIAL_BINS - 1)) begin
            rbin_w = RBW'(RADIAL_BINS - 1);
        end else begin
            rbin_w = rbin_raw[RBW-1:0];
        end
        // fold into the upper half plane
        if (r_v < 32'sd0) begin
            fold_u = -{r_u[31], r_u};
            fold_v = -{r_v[31], r_v};
        end else begin
            fold_u = {r_u[31], r_u};
            fold_v = {r_v[31], r_v};
        end
    end

    // angular sector from the CORDIC angle
    always_comb begin
        if (r_angle_bins == 4'd0) begin
            nsec = NSW'(1);
        end else if (32'(r_angle_bins) > 32'(ANGLE_BINS_MAX)) begin
            nsec = NSW'(ANGLE_BINS_MAX);
        end else begin
            nsec = NSW'(r_angle_bins);
        end
        ang_prod = (31 + NSW)'(cordic_angle) * (31 + NSW)'(nsec);
        abin_raw = ang_prod[30+NSW:30];
        abin_w   = (abin_raw >= {1'b0, nsec}) ? '0 : abin_raw[ABW-1:0];
        idx_w    = IW'(IW'(abin_w) * IW'(RADIAL_BINS) + IW'(r_rbin));
    end

    // count update and running totals
    always_comb begin
        cnt_w   = (mem_rdata < uvsb_pkg::CNT_MAX) ? (mem_rdata + 24'd1) : mem_rdata;
        sum_ext = {1'b0, r_sum} + {24'd0, r_frac};
        sum_w   = (sum_ext > {1'b0, uvsb_pkg::SUM_MAX}) ? uvsb_pkg::SUM_MAX : sum_ext[39:0];
        peak_w  = (r_frac > r_peak) ? r_frac : r_peak;
    end

    assign out_free   = !r_out_valid || o_result.ready;
    assign in_fire    = i_sample.valid && i_sample.ready;
    assign last_clear = (r_clr_ptr == IW'(DEPTH - 1));

    assign i_sample.ready   = (r_state == ST_IDLE);
    assign o_result.valid   = r_out_valid;
    assign o_result.payload = r_out;

    assign mem_we    = (r_state == ST_CLEAR) || ((r_state == ST_WRITE) && out_free);
    assign mem_waddr = (r_state == ST_CLEAR) ? r_clr_ptr : r_idx;
    assign mem_wdata = (r_state == ST_CLEAR) ? 24'd0 : cnt_w;

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (last_clear) begin
                    n_state = r_pending ? ST_MUL : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_fire) begin
                    n_state = i_sample.payload.restart ? ST_CLEAR : ST_MUL;
                end
            end
            ST_MUL: begin
                if (r_phase && (r_step == MS_VV)) begin
                    n_state = ST_SQRT;
                end else if (r_phase && (r_step == MS_RLO)) begin
                    n_state = ST_CORDIC;
                end
            end
            ST_SQRT: begin
                if (sqrt_done) begin
                    n_state = ST_MUL;
                end
            end
            ST_CORDIC: begin
                if (cordic_done) begin
                    n_state = ST_READ;
                end
            end
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sin_dec    <= uvsb_pkg::SIN_DEC_RST;
            r_cos_dec    <= uvsb_pkg::COS_DEC_RST;
            r_dish_diam  <= uvsb_pkg::DISH_DIAM_RST;
            r_diam_recip <= uvsb_pkg::DIAM_RECIP_RST;
            r_bin_origin <= uvsb_pkg::BIN_ORIGIN_RST;
            r_bw_recip   <= uvsb_pkg::BW_RECIP_RST;
            r_angle_bins <= uvsb_pkg::ANGLE_BINS_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                uvsb_pkg::CFG_SIN_DEC:    r_sin_dec    <= i_cfg_wdata[15:0];
                uvsb_pkg::CFG_COS_DEC:    r_cos_dec    <= i_cfg_wdata[15:0];
                uvsb_pkg::CFG_DISH_DIAM:  r_dish_diam  <= i_cfg_wdata[30:0];
                uvsb_pkg::CFG_DIAM_RECIP: r_diam_recip <= i_cfg_wdata;
                uvsb_pkg::CFG_BIN_ORIGIN: r_bin_origin <= i_cfg_wdata;
                uvsb_pkg::CFG_BW_RECIP:   r_bw_recip   <= i_cfg_wdata;
                uvsb_pkg::CFG_ANGLE_BINS: r_angle_bins <= i_cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    // control and datapath registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= ST_CLEAR;
            r_step         <= MS_SH_DX;
            r_phase        <= 1'b0;
            r_pending      <= 1'b0;
            r_clr_ptr      <= '0;
            r_sqrt_start   <= 1'b0;
            r_cordic_start <= 1'b0;
            r_sum          <= 40'd0;
            r_peak         <= 17'd0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_sqrt_start   <= (r_state == ST_MUL) && r_phase && (r_step == MS_VV);
            r_cordic_start <= (r_state == ST_MUL) && r_phase && (r_step == MS_RLO);
            // load on a finished sample, drop once the receiver takes it
            r_out_valid    <= ((r_state == ST_WRITE) && out_free) ||
                              (r_out_valid && !o_result.ready);
            case (r_state)
                ST_CLEAR: begin
                    r_clr_ptr <= last_clear ? '0 : (r_clr_ptr + IW'(1));
                end
                ST_IDLE: begin
                    if (in_fire) begin
                        r_in      <= i_sample.payload;
                        r_pending <= 1'b1;
                        r_step    <= MS_SH_DX;
                        r_phase   <= 1'b0;
                        r_clr_ptr <= '0;
                        if (i_sample.payload.restart) begin
                            r_sum  <= 40'd0;
                            r_peak <= 17'd0;
                        end
                    end
                end
                ST_MUL: begin
                    r_phase <= !r_phase;
                    if (!r_phase) begin
                        r_prod <= prod_w;
                    end else begin
                        r_step <= r_step + 4'd1;
                        case (r_step)
                            MS_SH_DX:  r_acc <= prod52;
                            MS_CH_DY:  r_u   <= sat32(rnd_acc);
                            MS_SD_CH:  r_c1  <= rnd_prod[17:0];
                            MS_SD_SH:  r_c2  <= rnd_prod[17:0];
                            MS_C1_DX:  r_acc <= -prod52;
                            MS_C2_DY:  r_acc <= acc_sum;
                            MS_CD_DZ:  r_v   <= sat32(rnd_acc);
                            MS_UU:     r_sq  <= r_prod[63:0];
                            MS_VV:     r_sq  <= r_sq + r_prod[63:0];
                            MS_SHADOW: r_frac <= frac_w;
                            MS_RHI:    r_hi   <= r_prod[48:0];
                            MS_RLO:    r_rbin <= rbin_w;
                            default: ;
                        endcase
                    end
                end
                ST_SQRT: begin
                    if (sqrt_done) begin
                        r_radius <= sqrt_root[31] ? uvsb_pkg::RADIUS_MAX : sqrt_root[30:0];
                        r_step   <= MS_SHADOW;
                        r_phase  <= 1'b0;
                    end
                end
                ST_CORDIC: begin
                    if (cordic_done) begin
                        r_abin <= abin_w;
                        r_idx  <= idx_w;
                    end
                end
                ST_WRITE: begin
                    // hold the updated count until the output register frees up
                    if (out_free) begin
                        r_pending         <= 1'b0;
                        r_sum             <= sum_w;
                        r_peak            <= peak_w;
                        r_out.u_coord     <= r_u;
                        r_out.v_coord     <= r_v;
                        r_out.uv_radius   <= r_radius;
                        r_out.shadow_frac <= r_frac;
                        r_out.radius_bin  <= 8'(r_rbin);
                        r_out.angle_bin   <= 3'(r_abin);
                        r_out.bin_count   <= cnt_w;
                        r_out.shadow_total <= sum_w;
                        r_out.shadow_peak <= peak_w;
                    end
                end
                default: ;
            endcase
        end
    end

    uvsb_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_sqrt_start),
        .i_radicand (r_sq),
        .o_done     (sqrt_done),
        .o_root     (sqrt_root)
    );

    uvsb_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_cordic_start),
        .i_x     (fold_u),
        .i_y     (fold_v),
        .o_done  (cordic_done),
        .o_angle (cordic_angle)
    );

    uvsb_hist_mem #(
        .DEPTH (DEPTH),
        .AW    (IW)
    ) u_hist_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    // the histogram is touched only by the sweep or by a count update
    `UVSB_ASSERT_IMPL(a_no_write_idle, (r_state == ST_IDLE), !mem_we, "histogram write in idle")
    // an accepted request always starts work
    `UVSB_ASSERT_NEXT(a_accept_busy, in_fire, (r_state != ST_IDLE), "accept without work")
    `UVSB_ASSERT_IMPL(a_sqrt_state, sqrt_done, (r_state == ST_SQRT), "stray square root done")
    `UVSB_ASSERT_IMPL(a_cordic_state, cordic_done, (r_state == ST_CORDIC), "stray angle done")
endmodule

// File: hw/rtl/uvsb_hist_mem.sv
module uvsb_hist_mem #(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [23:0]   i_wdata,
    input  logic [AW-1:0] i_raddr,
    output logic [23:0]   o_rdata
);
    logic [23:0] r_mem [DEPTH];
    logic [23:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hw/rtl/uvsb_sqrt.sv
module uvsb_sqrt (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_radicand,
    output logic        o_done,
    output logic [31:0] o_root
);
    logic [63:0] r_num;
    logic [34:0] r_rem;
    logic [31:0] r_root;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic        r_done;

    logic [34:0] rem_sh;
    logic [34:0] trial;
    logic        take;

    // one root bit per cycle
    always_comb begin
        rem_sh = {r_rem[32:0], r_num[63:62]};
        trial  = {1'b0, r_root, 2'b01};
        take   = (rem_sh >= trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 5'd0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'd31);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'd0;
                r_num  <= i_radicand;
                r_rem  <= 35'd0;
                r_root <= 32'd0;
            end else if (r_busy) begin
                r_num  <= {r_num[61:0], 2'b00};
                r_rem  <= take ? (rem_sh - trial) : rem_sh;
                r_root <= {r_root[30:0], take};
                r_cnt  <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule

// File: hw/rtl/uvsb_cordic.sv
module uvsb_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [32:0] i_x,
    input  logic signed [32:0] i_y,
    output logic               o_done,
    output logic [30:0]        o_angle
);
    logic signed [35:0] r_x;
    logic signed [35:0] r_y;
    logic signed [32:0] r_z;
    logic [3:0]         r_i;
    logic               r_busy;
    logic               r_done;
    logic [30:0]        r_angle;

    logic signed [35:0] x_sh;
    logic signed [35:0] y_sh;
    logic signed [35:0] nx;
    logic signed [35:0] ny;
    logic signed [32:0] nz;
    logic signed [32:0] arc;

    always_comb begin
        x_sh = r_x >>> r_i;
        y_sh = r_y >>> r_i;
        arc  = $signed({4'b0000, uvsb_pkg::arc_angle(r_i)});
        nx   = r_x;
        ny   = r_y;
        nz   = r_z;
        if (r_y > 36'sd0) begin
            nx = r_x + y_sh;
            ny = r_y - x_sh;
            nz = r_z + arc;
        end else if (r_y < 36'sd0) begin
            nx = r_x - y_sh;
            ny = r_y + x_sh;
            nz = r_z - arc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_i    <= 4'd0;
        end else begin
            r_done <= i_start ? (i_y == 33'sd0)
                              : (r_busy && (r_i == 4'(uvsb_pkg::CORDIC_STEPS - 1)));
            if (i_start) begin
                r_i <= 4'd0;
                if (i_y == 33'sd0) begin
                    // on the u axis: exact angle, no rotation
                    r_angle <= (i_x < 33'sd0) ? uvsb_pkg::HALF_TURN[30:0] : 31'd0;
                end else if (i_x < 33'sd0) begin
                    // rotate into the right half plane first
                    r_x    <= {{3{i_y[32]}}, i_y};
                    r_y    <= -{{3{i_x[32]}}, i_x};
                    r_z    <= uvsb_pkg::QUART_TURN;
                    r_busy <= 1'b1;
                end else begin
                    r_x    <= {{3{i_x[32]}}, i_x};
                    r_y    <= {{3{i_y[32]}}, i_y};
                    r_z    <= 33'sd0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_x <= nx;
                r_y <= ny;
                r_z <= nz;
                r_i <= r_i + 4'd1;
                if (r_i == 4'(uvsb_pkg::CORDIC_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    if (nz < 33'sd0) begin
                        r_angle <= 31'd0;
                    end else if (nz > uvsb_pkg::HALF_TURN) begin
                        r_angle <= uvsb_pkg::HALF_TURN[30:0];
                    end else begin
                        r_angle <= nz[30:0];
                    end
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_angle = r_angle;
endmodule

// File: tb/tb_uv_sample_binning_unit.sv
`timescale 1ns / 100ps

module tb_uv_sample_binning_unit;

    localparam int  NUM_CELLS   = uvsb_pkg::ANGLE_BINS_MAX_DEF * uvsb_pkg::RADIAL_BINS_DEF;
    // Cycles without any accepted request before the run is declared hung. The
    // worst honest gap is a restart sweep plus the sample latency plus stalls.
    localparam int  STALL_LIMIT = 20000;
    // Settle time after the last result.
    localparam int  DRAIN_WAIT  = 150;
    localparam longint PI_UNITS = 64'sd1073741824;

    // arctangent of 2^-i, binary angle units with pi = 2^30
    localparam longint ARC_STEP [16] = '{
        268435456, 158466703, 83729454, 42502379, 21333666, 10677233,
        5339919, 2670122, 1335082, 667543, 333772, 166886, 83443,
        41721, 20861, 10430
    };

    logic        i_clk;
    logic        i_rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_wdata;

    uvsb_chan_if #(.t_payload(uvsb_pkg::t_sample)) smp_if ();
    uvsb_chan_if #(.t_payload(uvsb_pkg::t_result)) res_if ();

    uv_sample_binning_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample    (smp_if),
        .o_result    (res_if),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    // Shadow copy of the block's registers and state.
    longint      sin_dec_q, cos_dec_q, diam_q, diam_recip_q, origin_q, bw_recip_q, sectors_q;
    int unsigned bin_tally [NUM_CELLS];
    longint      shadow_sum_q, shadow_peak_q;

    uvsb_pkg::t_sample sample_backlog [$];   // requests waiting to be driven
    uvsb_pkg::t_result expected_bins  [$];   // predicted results, oldest first

    int send_idle_pct;   // chance per cycle that the sender holds off
    int recv_idle_pct;   // chance per cycle that the receiver stalls
    int mismatches = 0;
    int quiet_cycles;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic longint round_shift(longint x, int n);
        return (x + (longint'(1) << (n - 1))) >>> n;
    endfunction

    function automatic longint clip32(longint x);
        if (x > 64'sd2147483647)
            return 64'sd2147483647;
        if (x < -64'sd2147483648)
            return -64'sd2147483648;
        return x;
    endfunction

    function automatic longint unsigned floor_sqrt(longint unsigned n);
        longint unsigned root = 0;
        longint unsigned b    = 64'h4000_0000_0000_0000;
        while (b > n)
            b >>= 2;
        while (b != 0) begin
            if (n >= root + b) begin
                n    = n - (root + b);
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        return root;
    endfunction

    // Angle of (x, y) with y >= 0 by vectoring CORDIC; pi = 2^30.
    function automatic longint half_plane_angle(longint x, longint y);
        longint z = 0;
        longint nx;
        if (y == 0)
            return (x < 0) ? PI_UNITS : 0;
        if (x < 0) begin
            // rotate by -90 degrees so the iterations converge
            nx = y;
            y  = -x;
            x  = nx;
            z  = PI_UNITS / 2;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                x  = nx;
                z  = z + ARC_STEP[i];
            end else if (y < 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                x  = nx;
                z  = z - ARC_STEP[i];
            end
        end
        if (z < 0)
            z = 0;
        if (z > PI_UNITS)
            z = PI_UNITS;
        return z;
    endfunction

    function automatic uvsb_pkg::t_result predict_binning(uvsb_pkg::t_sample s);
        longint dx, dy, dz, sh, ch, u, v, c1, c2, r, frac, diff, rbin, fu, fv, ang, nsec;
        longint abin, hi, lo;
        longint unsigned sq;
        int slot;
        uvsb_pkg::t_result res;

        dx = longint'(s.delta_x);
        dy = longint'(s.delta_y);
        dz = longint'(s.delta_z);
        sh = longint'(s.sin_hour);
        ch = longint'(s.cos_hour);

        if (s.restart) begin
            foreach (bin_tally[k])
                bin_tally[k] = 0;
            shadow_sum_q  = 0;
            shadow_peak_q = 0;
        end

        // uv projection
        u  = clip32(round_shift(sh * dx + ch * dy, 14));
        c1 = round_shift(sin_dec_q * ch, 14);
        c2 = round_shift(sin_dec_q * sh, 14);
        v  = clip32(round_shift(-c1 * dx + c2 * dy + cos_dec_q * dz, 14));

        sq = longint'(u * u);
        sq = sq + longint'(v * v);
        r  = longint'(floor_sqrt(sq));
        if (r > 64'sd2147483647)
            r = 64'sd2147483647;

        // dish shadowing
        frac = 0;
        if (r < diam_q) begin
            frac = ((diam_q - r) * diam_recip_q) >>> 24;
            if (frac > 65536)
                frac = 65536;
        end

        // radial bin, clamped at both ends
        diff = r - origin_q;
        if (diff <= 0) begin
            rbin = 0;
        end else begin
            hi   = (diff >>> 16) * bw_recip_q;
            lo   = ((diff & 64'hFFFF) * bw_recip_q) >>> 16;
            rbin = (hi + lo) >>> 24;
            if (rbin > uvsb_pkg::RADIAL_BINS_DEF - 1)
                rbin = uvsb_pkg::RADIAL_BINS_DEF - 1;
        end

        // fold into the upper half plane, then find the sector
        fu = u;
        fv = v;
        if (fv < 0) begin
            fu = -fu;
            fv = -fv;
        end
        ang  = half_plane_angle(fu, fv);
        nsec = sectors_q;
        if (nsec == 0)
            nsec = 1;
        if (nsec > uvsb_pkg::ANGLE_BINS_MAX_DEF)
            nsec = uvsb_pkg::ANGLE_BINS_MAX_DEF;
        abin = (ang * nsec) >>> 30;
        if (abin >= nsec)
            abin = 0;

        slot = int'(abin * uvsb_pkg::RADIAL_BINS_DEF + rbin);
        if (bin_tally[slot] < 32'hFFFFFF)
            bin_tally[slot]++;

        shadow_sum_q = shadow_sum_q + frac;
        if (shadow_sum_q > 64'hFF_FFFF_FFFF)
            shadow_sum_q = 64'hFF_FFFF_FFFF;
        if (frac > shadow_peak_q)
            shadow_peak_q = frac;

        res.u_coord      = u[31:0];
        res.v_coord      = v[31:0];
        res.uv_radius    = r[30:0];
        res.shadow_frac  = frac[16:0];
        res.radius_bin   = rbin[7:0];
        res.angle_bin    = abin[2:0];
        res.bin_count    = bin_tally[slot][23:0];
        res.shadow_total = shadow_sum_q[39:0];
        res.shadow_peak  = shadow_peak_q[16:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Driver: one request per handshake, never retracted while stalled
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            smp_if.valid <= 1'b0;
        end else begin
            if (smp_if.valid && smp_if.ready)
                expected_bins.push_back(predict_binning(smp_if.payload));
            if (!smp_if.valid || smp_if.ready) begin
                if (sample_backlog.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    smp_if.valid   <= 1'b1;
                    smp_if.payload <= sample_backlog.pop_front();
                end else begin
                    smp_if.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Monitor: compare each result with the oldest prediction
    // ------------------------------------------------------------------
    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        $display("mismatch %s: got 0x%0h, want 0x%0h at %0t", field, got, want, $time);
        mismatches++;
    endtask

    task automatic check_field(string field, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report_mismatch(field, got, want);
    endtask

    always @(posedge i_clk) begin
        uvsb_pkg::t_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            res_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            if (res_if.valid && res_if.ready) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch("unexpected result", res_if.payload.u_coord, 0);
                end else begin
                    want = expected_bins.pop_front();
                    check_field("u_coord",      res_if.payload.u_coord,      want.u_coord);
                    check_field("v_coord",      res_if.payload.v_coord,      want.v_coord);
                    check_field("uv_radius",    res_if.payload.uv_radius,    want.uv_radius);
                    check_field("shadow_frac",  res_if.payload.shadow_frac,  want.shadow_frac);
                    check_field("radius_bin",   res_if.payload.radius_bin,   want.radius_bin);
                    check_field("angle_bin",    res_if.payload.angle_bin,    want.angle_bin);
                    check_field("bin_count",    res_if.payload.bin_count,    want.bin_count);
                    check_field("shadow_total", res_if.payload.shadow_total, want.shadow_total);
                    check_field("shadow_peak",  res_if.payload.shadow_peak,  want.shadow_peak);
                end
            end
        end
    end

    // Watchdog: any accepted request on either side restarts the count.
    always @(posedge i_clk) begin
        if (!i_rst_n || (smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[uv_sample_binning_unit] ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            uvsb_pkg::CFG_SIN_DEC:    sin_dec_q    = longint'($signed(val[15:0]));
            uvsb_pkg::CFG_COS_DEC:    cos_dec_q    = longint'($signed(val[15:0]));
            uvsb_pkg::CFG_DISH_DIAM:  diam_q       = longint'(val[30:0]);
            uvsb_pkg::CFG_DIAM_RECIP: diam_recip_q = longint'(val);
            uvsb_pkg::CFG_BIN_ORIGIN: origin_q     = longint'($signed(val));
            uvsb_pkg::CFG_BW_RECIP:   bw_recip_q   = longint'(val);
            uvsb_pkg::CFG_ANGLE_BINS: sectors_q    = longint'(val[3:0]);
            default: ;
        endcase
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(int sdec, int cdec, logic [31:0] diam, logic [31:0] drecip,
                                 logic [31:0] origin, logic [31:0] bwrecip, int sectors);
        write_reg(uvsb_pkg::CFG_SIN_DEC,    sdec);
        write_reg(uvsb_pkg::CFG_COS_DEC,    cdec);
        write_reg(uvsb_pkg::CFG_DISH_DIAM,  diam);
        write_reg(uvsb_pkg::CFG_DIAM_RECIP, drecip);
        write_reg(uvsb_pkg::CFG_BIN_ORIGIN, origin);
        write_reg(uvsb_pkg::CFG_BW_RECIP,   bwrecip);
        write_reg(uvsb_pkg::CFG_ANGLE_BINS, sectors);
    endtask

    // Hold until every request is out and answered, then let the pipeline settle.
    task automatic wait_drained();
        while (sample_backlog.size() > 0 || smp_if.valid || expected_bins.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    function automatic uvsb_pkg::t_sample mk_sample(int rs, logic [31:0] dx, logic [31:0] dy,
                                                    logic [31:0] dz, int sh, int ch);
        uvsb_pkg::t_sample s;
        s.restart  = rs[0];
        s.delta_x  = dx;
        s.delta_y  = dy;
        s.delta_z  = dz;
        s.sin_hour = 16'(sh);
        s.cos_hour = 16'(ch);
        return s;
    endfunction

    // Most deltas stay near the dish so shadowing and low bins get hit; some
    // spread wider and the rest over the full 32-bit range.
    function automatic logic [31:0] rand_delta();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60)
            return 32'(longint'($urandom_range(0, 1 << 22)) - (1 << 21));
        if (sel < 85)
            return 32'(longint'($urandom_range(0, 1 << 27)) - (1 << 26));
        return $urandom;
    endfunction

    function automatic int rand_trig();
        if ($urandom_range(0, 9) == 0)
            return $urandom_range(0, 1) ? 16384 : -16384;
        return int'($urandom_range(0, 32768)) - 16384;
    endfunction

    task automatic queue_random(int count);
        repeat (count)
            sample_backlog.push_back(mk_sample(int'($urandom_range(0, 49) == 0), rand_delta(),
                                               rand_delta(), rand_delta(), rand_trig(),
                                               rand_trig()));
    endtask

    localparam logic [31:0] WL = 32'd65536;   // one wavelength, Q16.16

    initial begin
        i_rst_n        = 1'b0;
        cfg_we         = 1'b0;
        cfg_index      = '0;
        cfg_wdata      = '0;
        send_idle_pct  = 16;
        recv_idle_pct  = 69;

        sin_dec_q    = longint'(uvsb_pkg::SIN_DEC_RST);
        cos_dec_q    = longint'(uvsb_pkg::COS_DEC_RST);
        diam_q       = longint'(uvsb_pkg::DISH_DIAM_RST);
        diam_recip_q = longint'(uvsb_pkg::DIAM_RECIP_RST);
        origin_q     = longint'(uvsb_pkg::BIN_ORIGIN_RST);
        bw_recip_q   = longint'(uvsb_pkg::BW_RECIP_RST);
        sectors_q    = longint'(uvsb_pkg::ANGLE_BINS_RST);
        foreach (bin_tally[k])
            bin_tally[k] = 0;
        shadow_sum_q  = 0;
        shadow_peak_q = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part: 8-wavelength bins starting at 2 wavelengths, 45 deg source.
        load_settings(11585, 11585, 655360, 1677722, 2 * WL, 2097152, 8);
        // origin: radius zero, full shadow, radial offset below zero clamped to bin zero
        sample_backlog.push_back(mk_sample(1, 0, 0, 0, 16384, 0));
        // point on the positive u axis
        sample_backlog.push_back(mk_sample(0, 7 * WL, 0, 0, 16384, 0));
        // point on the negative u axis: sector wraps to zero
        sample_backlog.push_back(mk_sample(0, -5 * WL, 0, 0, 16384, 0));
        // v below zero: fold both coordinates
        sample_backlog.push_back(mk_sample(0, 0, 0, -20 * WL, 0, 16384));
        sample_backlog.push_back(mk_sample(0, 3 * WL, -2 * WL, -9 * WL, -11585, 11585));
        // same bin three times
        repeat (3)
            sample_backlog.push_back(mk_sample(0, 3 * WL, 0, 0, 16384, 0));
        // extremes: saturated u, radial clamp
        sample_backlog.push_back(mk_sample(0, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
                                           16384, 16384));
        sample_backlog.push_back(mk_sample(0, 32'h80000000, 32'h80000000, 32'h80000000,
                                           -16384, -16384));
        sample_backlog.push_back(mk_sample(0, 32'h7FFFFFFF, 32'h80000000, 0,
                                           16384, -16384));
        sample_backlog.push_back(mk_sample(0, 5000 * WL, 0, 0, 16384, 0));
        // restart in the middle, then refill the cleared bin
        sample_backlog.push_back(mk_sample(1, 3 * WL, 0, 0, 16384, 0));
        sample_backlog.push_back(mk_sample(0, 3 * WL, 0, 0, 16384, 0));
        // points near the dish edge on the u and v axes, then one next to the origin
        sample_backlog.push_back(mk_sample(0, 6 * WL, 6 * WL, 0, 16384, 16384));
        sample_backlog.push_back(mk_sample(0, -6 * WL, 6 * WL, 0, 16384, 16384));
        sample_backlog.push_back(mk_sample(0, 0, 0, 12 * WL, -16384, -16384));
        sample_backlog.push_back(mk_sample(0, 32'hFFFFFFFF, 1, 32'hFFFFFFFF, 1, -1));
        wait_drained();

        // Random part: sender idles lightly, receiver stalls heavily.
        load_settings(8192, 14189, 655360, 1677722, 0, 67108864, 8);
        queue_random(500);
        wait_drained();

        // Swap the idling; extreme settings with a single sector.
        send_idle_pct = 69;
        recv_idle_pct = 16;
        load_settings(-16384, 0, 32'h7FFFFFFF, 32'hFFFFFFFF, 32'h80000000, 0, 1);
        queue_random(500);
        wait_drained();

        // No idling from here on; opposite extremes, oversized sector count.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        load_settings(16384, -16384, 1, 0, 32'h7FFFFFFF, 32'hFFFFFFFF, 15);
        queue_random(500);
        wait_drained();

        // zero sectors, negative origin
        load_settings(-5000, 15600, 3276800, 335544, -4 * WL, 33554432, 0);
        queue_random(250);
        wait_drained();
        load_settings(3000, -9000, 1310720, 838861, WL, 16777216, 5);
        queue_random(250);
        wait_drained();

        if (mismatches == 0)
            $display("[uv_sample_binning_unit] OK");
        else
            $display("[uv_sample_binning_unit] ERROR");
        $finish;
    end

endmodule

// File: uv_sample_binning_unit.f
+incdir+hw/rtl
hw/rtl/uvsb_pkg.sv
hw/rtl/uvsb_chan_if.sv
hw/rtl/uvsb_hist_mem.sv
hw/rtl/uvsb_sqrt.sv
hw/rtl/uvsb_cordic.sv
hw/rtl/uv_sample_binning_unit.sv
tb/tb_uv_sample_binning_unit.sv
